// ===== hw/rtl/ffra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes of the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    typedef logic [31:0] word_t;

    // result status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NO_TYPE       = 3'd1;
    localparam logic [2:0] ST_BLOCKS_FULL   = 3'd2;
    localparam logic [2:0] ST_RANGES_FULL   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_BLOCK = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_SIZE = 2'd0;
    localparam logic [1:0] CFG_TYPE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_TYPE_FLAGS   = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam word_t DFLT_BLOCK_SIZE = 32'd16777216;
    localparam logic [2:0] TYPES_EXIST = 3'd4;

    // one block table entry
    typedef struct packed {
        word_t       length;
        word_t       cursor;
        logic [1:0]  kind;
    } blk_ent_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffra_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_if
// Request and response channels (valid/ready) of the range allocator.
// ----------------------------------------------------------------------------
interface ffra_req_if import ffra_pkg::*; ();
    logic         valid;
    logic         ready;
    logic         mode;
    word_t        size;
    logic [30:0]  alignment;
    logic [3:0]   type_mask;
    logic [7:0]   required_flags;
    logic [2:0]   block_number;
    word_t        start_offset;

    modport source (output valid, mode, size, alignment, type_mask, required_flags,
                    block_number, start_offset, input ready);
    modport sink   (input valid, mode, size, alignment, type_mask, required_flags,
                    block_number, start_offset, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
    logic         valid;
    logic         ready;
    logic [2:0]   status;
    logic [2:0]   granted_block;
    word_t        granted_offset;
    logic [1:0]   granted_type;

    modport source (output valid, status, granted_block, granted_offset, granted_type,
                    input ready);
    modport sink   (input valid, status, granted_block, granted_offset, granted_type,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_range_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Allocate: blocks are read from the table in turn; for each block of the chosen type the
//   range walk runs, then the cursor is tried; a new block is made if none fits.
//   The walk visits every slot, reads each valid one and fit-tests those the block owns.
//   Free: block check and range walk, no fit test; an unknown block or zero length skips the walk.
// Throughput: one transaction at a time; a stalled result only holds the next one.
// Reset: tables empty at once (valid bits in flops, block count cleared); no clearing pass.
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit sub-allocator over typed blocks with a coalescing free-range table.
// ----------------------------------------------------------------------------
module first_fit_range_allocator import ffra_pkg::*; #(
    parameter int MAX_BLOCKS = 8,
    parameter int MAX_RANGES = 32,
    parameter int NUM_TYPES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    ffra_req_if.sink    req,
    ffra_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;   // block index
    localparam int BCW = $clog2(MAX_BLOCKS + 1);                      // block count
    localparam int RIW = $clog2(MAX_RANGES);                          // range index
    localparam int RCW = $clog2(MAX_RANGES + 1);                      // range count
    localparam int RW  = BIW + 64;                                    // owner,start,len
    localparam int BW  = $bits(blk_ent_t);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TSEL = 5'd1;   // normalize alignment, pick type
    localparam logic [4:0] S_BRD  = 5'd2;   // read block entry
    localparam logic [4:0] S_BCHK = 5'd3;   // check block kind
    localparam logic [4:0] S_RRD  = 5'd4;   // read range slot
    localparam logic [4:0] S_RPAD = 5'd5;   // range data back: owner, padding
    localparam logic [4:0] S_RCHK = 5'd6;   // fit test, track lowest start
    localparam logic [4:0] S_HIT1 = 5'd7;   // aligned start, tail
    localparam logic [4:0] S_HIT2 = 5'd8;   // rewrite chosen range
    localparam logic [4:0] S_HIT3 = 5'd9;   // write tail into empty slot
    localparam logic [4:0] S_CUR1 = 5'd10;  // cursor padding
    localparam logic [4:0] S_CUR2 = 5'd11;  // aligned cursor
    localparam logic [4:0] S_CUR3 = 5'd12;  // cursor fit, write back
    localparam logic [4:0] S_NEW1 = 5'd13;  // new block size sum
    localparam logic [4:0] S_NEW2 = 5'd14;  // clamp, create block
    localparam logic [4:0] S_FCHK = 5'd15;  // free: block check, end
    localparam logic [4:0] S_FLEN = 5'd16;  // free: length
    localparam logic [4:0] S_FMRG = 5'd17;  // free: neighbor tests
    localparam logic [4:0] S_FWR  = 5'd18;  // free: write back
    localparam logic [4:0] S_DONE = 5'd19;  // hand result to output register

    // control state
    logic [4:0]            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BCW-1:0]        blocks_used_reg, blocks_used_next;
    logic [MAX_RANGES-1:0] rvalid_reg, rvalid_next;
    word_t                 dflt_reg;
    logic [2:0]            tcount_reg;
    word_t                 tflags_reg;

    // transaction payload
    logic        mode_reg, mode_next;
    word_t       sz_reg, sz_next;
    logic [30:0] a_reg, a_next;
    logic [30:0] amask_reg, amask_next;
    logic [3:0]  mask_reg, mask_next;
    logic [7:0]  rflags_reg, rflags_next;
    word_t       begin_reg, begin_next;
    logic [2:0]  bnum_reg, bnum_next;
    logic [1:0]  t_reg, t_next;
    logic        have_slot_reg, have_slot_next;

    logic [BCW-1:0] bcnt_reg, bcnt_next;
    logic [BIW-1:0] blk_reg, blk_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;

    word_t       st_reg, st_next;
    word_t       ln_reg, ln_next;
    logic [30:0] pad_reg, pad_next;

    logic           best_found_reg, best_found_next;
    logic [RIW-1:0] best_idx_reg, best_idx_next;
    word_t          best_st_reg, best_st_next;
    word_t          best_ln_reg, best_ln_next;
    logic [30:0]    best_pad_reg, best_pad_next;
    logic [32:0]    best_need_reg, best_need_next;

    word_t       al_reg, al_next;
    word_t       hend_reg, hend_next;
    word_t       tail_reg, tail_next;
    word_t       cur_reg, cur_next;
    word_t       blen_reg, blen_next;
    logic [32:0] c_reg, c_next;
    logic [32:0] nsum_reg, nsum_next;

    word_t          end_reg, end_next;
    word_t          flen_reg, flen_next;
    logic           prev_found_reg, prev_found_next;
    logic [RIW-1:0] prev_idx_reg, prev_idx_next;
    word_t          prev_st_reg, prev_st_next;
    word_t          prev_ln_reg, prev_ln_next;
    logic           next_found_reg, next_found_next;
    logic [RIW-1:0] next_idx_reg, next_idx_next;
    word_t          next_st_reg, next_st_next;
    word_t          next_ln_reg, next_ln_next;
    logic           mp_reg, mp_next;
    logic           mn_reg, mn_next;
    word_t          sum1_reg, sum1_next;

    logic [2:0] res_status_reg, res_status_next;
    logic [2:0] res_blk_reg, res_blk_next;
    word_t      res_off_reg, res_off_next;
    logic [1:0] res_type_reg, res_type_next;

    logic [2:0] out_status_reg, out_status_next;
    logic [2:0] out_blk_reg, out_blk_next;
    word_t      out_off_reg, out_off_next;
    logic [1:0] out_type_reg, out_type_next;

    // memory ports
    logic           rr_we, rr_re;
    logic [RIW-1:0] rr_waddr, rr_raddr;
    logic [RW-1:0]  rr_wdata, rr_rdata;
    logic           br_we, br_re;
    logic [BIW-1:0] br_waddr, br_raddr;
    blk_ent_t       br_wdata, br_rdata;
    logic [BW-1:0]  br_rdata_raw;

    logic [BIW-1:0] rd_owner;
    word_t          rd_start, rd_len;

    // lowest empty range slot
    logic           slot_found;
    logic [RIW-1:0] slot_idx;

    // alignment normalize and type pick
    logic [30:0] a_low;
    logic [2:0]  tn;
    logic        t_found;
    logic [1:0]  t_pick;

    // scratch
    logic [32:0] need;
    logic        fit, split;
    logic [32:0] fsum;
    logic [33:0] cend;
    word_t       nlen;

    ffra_ram #(.WIDTH(RW), .DEPTH(MAX_RANGES)) u_range_ram (
        .clk   (clk),
        .we    (rr_we),
        .waddr (rr_waddr),
        .wdata (rr_wdata),
        .re    (rr_re),
        .raddr (rr_raddr),
        .rdata (rr_rdata)
    );

    ffra_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_block_ram (
        .clk   (clk),
        .we    (br_we),
        .waddr (br_waddr),
        .wdata (br_wdata),
        .re    (br_re),
        .raddr (br_raddr),
        .rdata (br_rdata_raw)
    );

    assign br_rdata = blk_ent_t'(br_rdata_raw);
    assign rd_owner = rr_rdata[RW-1 -: BIW];
    assign rd_start = rr_rdata[63:32];
    assign rd_len   = rr_rdata[31:0];

    // handshake: take a transaction only when the sequencer is free; a result
    // waiting in the output register does not hold off the next request
    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.granted_block  = out_blk_reg;
    assign rsp.granted_offset = out_off_reg;
    assign rsp.granted_type   = out_type_reg;

    always_comb
    begin
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = MAX_RANGES - 1; i >= 0; i--)
        begin
            if (!rvalid_reg[i])
            begin
                slot_found = 1'b1;
                slot_idx   = RIW'(i);
            end
        end
    end

    // mask through the lowest set bit of alignment; zero acts as one
    assign a_low = a_reg ^ (a_reg - 31'd1);

    always_comb
    begin
        tn = (tcount_reg > TYPES_EXIST) ? TYPES_EXIST : tcount_reg;
        t_found = 1'b0;
        t_pick  = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if (i < NUM_TYPES && 3'(i) < tn && mask_reg[i]
                && (tflags_reg[8*i +: 8] & rflags_reg) == rflags_reg)
            begin
                t_found = 1'b1;
                t_pick  = 2'(i);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        blocks_used_next = blocks_used_reg;
        rvalid_next      = rvalid_reg;

        mode_next      = mode_reg;
        sz_next        = sz_reg;
        a_next         = a_reg;
        amask_next     = amask_reg;
        mask_next      = mask_reg;
        rflags_next    = rflags_reg;
        begin_next     = begin_reg;
        bnum_next      = bnum_reg;
        t_next         = t_reg;
        have_slot_next = have_slot_reg;
        bcnt_next      = bcnt_reg;
        blk_next       = blk_reg;
        rcnt_next      = rcnt_reg;
        st_next        = st_reg;
        ln_next        = ln_reg;
        pad_next       = pad_reg;
        best_found_next = best_found_reg;
        best_idx_next  = best_idx_reg;
        best_st_next   = best_st_reg;
        best_ln_next   = best_ln_reg;
        best_pad_next  = best_pad_reg;
        best_need_next = best_need_reg;
        al_next        = al_reg;
        hend_next      = hend_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        blen_next      = blen_reg;
        c_next         = c_reg;
        nsum_next      = nsum_reg;
        end_next       = end_reg;
        flen_next      = flen_reg;
        prev_found_next = prev_found_reg;
        prev_idx_next  = prev_idx_reg;
        prev_st_next   = prev_st_reg;
        prev_ln_next   = prev_ln_reg;
        next_found_next = next_found_reg;
        next_idx_next  = next_idx_reg;
        next_st_next   = next_st_reg;
        next_ln_next   = next_ln_reg;
        mp_next        = mp_reg;
        mn_next        = mn_reg;
        sum1_next      = sum1_reg;
        res_status_next = res_status_reg;
        res_blk_next   = res_blk_reg;
        res_off_next   = res_off_reg;
        res_type_next  = res_type_reg;
        out_status_next = out_status_reg;
        out_blk_next   = out_blk_reg;
        out_off_next   = out_off_reg;
        out_type_next  = out_type_reg;

        rr_we    = 1'b0;
        rr_waddr = '0;
        rr_wdata = '0;
        rr_re    = 1'b0;
        rr_raddr = rcnt_reg[RIW-1:0];
        br_we    = 1'b0;
        br_waddr = blk_reg;
        br_wdata = '0;
        br_re    = 1'b0;
        br_raddr = bcnt_reg[BIW-1:0];

        need  = 33'(pad_reg) + 33'(sz_reg);
        fit   = {1'b0, ln_reg} >= need;
        split = (pad_reg != '0) && ({1'b0, ln_reg} != need);
        fsum  = 33'(begin_reg) + 33'(sz_reg);
        cend  = 34'(c_reg) + 34'(sz_reg);
        nlen  = nsum_reg[32] ? 32'hFFFF_FFFF : nsum_reg[31:0];
        if (nlen < dflt_reg)
        begin
            nlen = dflt_reg;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next   = req.mode;
                    sz_next     = req.size;
                    a_next      = req.alignment;
                    mask_next   = req.type_mask;
                    rflags_next = req.required_flags;
                    bnum_next   = req.block_number;
                    begin_next  = req.start_offset;
                    state_next  = S_TSEL;
                end
            end

            S_TSEL:
            begin
                a_next          = (a_reg == '0) ? 31'd1 : (a_low & a_reg);
                amask_next      = (a_reg == '0) ? '0 : (a_low >> 1);
                t_next          = t_pick;
                have_slot_next  = slot_found;
                bcnt_next       = '0;
                res_status_next = ST_OK;
                res_blk_next    = '0;
                res_off_next    = '0;
                res_type_next   = '0;
                if (mode_reg == MODE_FREE)
                begin
                    state_next = S_FCHK;
                end
                else if (!t_found)
                begin
                    res_status_next = ST_NO_TYPE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end

            S_BRD:
            begin
                if (bcnt_reg == blocks_used_reg)
                begin
                    state_next = S_NEW1;
                end
                else
                begin
                    br_re      = 1'b1;
                    blk_next   = bcnt_reg[BIW-1:0];
                    state_next = S_BCHK;
                end
            end

            S_BCHK:
            begin
                if (br_rdata.kind != t_reg)
                begin
                    bcnt_next  = bcnt_reg + BCW'(1);
                    state_next = S_BRD;
                end
                else
                begin
                    cur_next        = br_rdata.cursor;
                    blen_next       = br_rdata.length;
                    rcnt_next       = '0;
                    best_found_next = 1'b0;
                    state_next      = S_RRD;
                end
            end

            S_RRD:
            begin
                if (rcnt_reg == RCW'(MAX_RANGES))
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        state_next = S_FMRG;
                    end
                    else if (best_found_reg)
                    begin
                        state_next = S_HIT1;
                    end
                    else
                    begin
                        state_next = S_CUR1;
                    end
                end
                else if (rvalid_reg[rcnt_reg[RIW-1:0]])
                begin
                    rr_re      = 1'b1;
                    state_next = S_RPAD;
                end
                else
                begin
                    rcnt_next = rcnt_reg + RCW'(1);
                end
            end

            S_RPAD:
            begin
                state_next = S_RRD;
                if (rd_owner != blk_reg)
                begin
                    rcnt_next = rcnt_reg + RCW'(1);
                end
                else if (mode_reg == MODE_ALLOC)
                begin
                    st_next    = rd_start;
                    ln_next    = rd_len;
                    pad_next   = 31'(32'd0 - rd_start) & amask_reg;
                    state_next = S_RCHK;
                end
                else
                begin
                    rcnt_next = rcnt_reg + RCW'(1);
                    if (rd_start < begin_reg)
                    begin
                        if (!prev_found_reg || rd_start > prev_st_reg)
                        begin
                            prev_found_next = 1'b1;
                            prev_idx_next   = rcnt_reg[RIW-1:0];
                            prev_st_next    = rd_start;
                            prev_ln_next    = rd_len;
                        end
                    end
                    else if (!next_found_reg || rd_start < next_st_reg)
                    begin
                        next_found_next = 1'b1;
                        next_idx_next   = rcnt_reg[RIW-1:0];
                        next_st_next    = rd_start;
                        next_ln_next    = rd_len;
                    end
                end
            end

            S_RCHK:
            begin
                rcnt_next  = rcnt_reg + RCW'(1);
                state_next = S_RRD;
                // a range needing a split is unusable with no slot for the tail
                if (fit && !(split && !have_slot_reg)
                    && (!best_found_reg || st_reg < best_st_reg))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rcnt_reg[RIW-1:0];
                    best_st_next    = st_reg;
                    best_ln_next    = ln_reg;
                    best_pad_next   = pad_reg;
                    best_need_next  = need;
                end
            end

            S_HIT1:
            begin
                al_next    = best_st_reg + 32'(best_pad_reg);
                hend_next  = 32'(33'(best_st_reg) + best_need_reg);
                tail_next  = best_ln_reg - best_need_reg[31:0];
                state_next = S_HIT2;
            end

            S_HIT2:
            begin
                res_blk_next  = 3'(blk_reg);
                res_off_next  = al_reg;
                res_type_next = t_reg;
                state_next    = S_DONE;
                rr_waddr      = best_idx_reg;
                if (best_pad_reg != '0)
                begin
                    // padding stays free in place; tail needs its own slot
                    rr_we    = 1'b1;
                    rr_wdata = {blk_reg, best_st_reg, 32'(best_pad_reg)};
                    if (tail_reg != '0)
                    begin
                        state_next = S_HIT3;
                    end
                end
                else if (tail_reg != '0)
                begin
                    rr_we    = 1'b1;
                    rr_wdata = {blk_reg, hend_reg, tail_reg};
                end
                else
                begin
                    rvalid_next[best_idx_reg] = 1'b0;
                end
            end

            S_HIT3:
            begin
                rr_we                 = 1'b1;
                rr_waddr              = slot_idx;
                rr_wdata              = {blk_reg, hend_reg, tail_reg};
                rvalid_next[slot_idx] = 1'b1;
                state_next            = S_DONE;
            end

            S_CUR1:
            begin
                pad_next   = 31'(32'd0 - cur_reg) & amask_reg;
                state_next = S_CUR2;
            end

            S_CUR2:
            begin
                c_next     = 33'(cur_reg) + 33'(pad_reg);
                state_next = S_CUR3;
            end

            S_CUR3:
            begin
                if (cend <= 34'(blen_reg))
                begin
                    br_we         = 1'b1;
                    br_wdata      = '{length: blen_reg, cursor: cend[31:0], kind: t_reg};
                    res_blk_next  = 3'(blk_reg);
                    res_off_next  = c_reg[31:0];
                    res_type_next = t_reg;
                    state_next    = S_DONE;
                end
                else
                begin
                    bcnt_next  = bcnt_reg + BCW'(1);
                    state_next = S_BRD;
                end
            end

            S_NEW1:
            begin
                if (blocks_used_reg >= BCW'(MAX_BLOCKS))
                begin
                    res_status_next = ST_BLOCKS_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    nsum_next  = 33'(sz_reg) + 33'(a_reg);
                    state_next = S_NEW2;
                end
            end

            S_NEW2:
            begin
                br_we            = 1'b1;
                br_waddr         = blocks_used_reg[BIW-1:0];
                br_wdata         = '{length: nlen, cursor: sz_reg, kind: t_reg};
                blocks_used_next = blocks_used_reg + BCW'(1);
                res_blk_next     = 3'(blocks_used_reg);
                res_off_next     = '0;
                res_type_next    = t_reg;
                state_next       = S_DONE;
            end

            S_FCHK:
            begin
                if (8'(bnum_reg) >= 8'(blocks_used_reg))
                begin
                    res_status_next = ST_UNKNOWN_BLOCK;
                    state_next      = S_DONE;
                end
                else
                begin
                    blk_next   = BIW'(bnum_reg);
                    end_next   = fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
                    state_next = S_FLEN;
                end
            end

            S_FLEN:
            begin
                flen_next       = end_reg - begin_reg;
                prev_found_next = 1'b0;
                next_found_next = 1'b0;
                rcnt_next       = '0;
                state_next      = (end_reg == begin_reg) ? S_DONE : S_RRD;
            end

            S_FMRG:
            begin
                mp_next   = prev_found_reg
                            && (33'(prev_st_reg) + 33'(prev_ln_reg) == 33'(begin_reg));
                mn_next   = next_found_reg && (end_reg == next_st_reg);
                sum1_next = prev_ln_reg + flen_reg;
                // freeing at the start of a free range is a no-op
                if (next_found_reg && next_st_reg == begin_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FWR;
                end
            end

            S_FWR:
            begin
                state_next = S_DONE;
                if (mp_reg)
                begin
                    rr_we    = 1'b1;
                    rr_waddr = prev_idx_reg;
                    rr_wdata = {blk_reg, prev_st_reg,
                                mn_reg ? (sum1_reg + next_ln_reg) : sum1_reg};
                    if (mn_reg)
                    begin
                        rvalid_next[next_idx_reg] = 1'b0;
                    end
                end
                else if (mn_reg)
                begin
                    rr_we    = 1'b1;
                    rr_waddr = next_idx_reg;
                    rr_wdata = {blk_reg, begin_reg, flen_reg + next_ln_reg};
                end
                else if (!slot_found)
                begin
                    res_status_next = ST_RANGES_FULL;
                end
                else
                begin
                    rr_we                 = 1'b1;
                    rr_waddr              = slot_idx;
                    rr_wdata              = {blk_reg, begin_reg, flen_reg};
                    rvalid_next[slot_idx] = 1'b1;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_blk_next    = res_blk_reg;
                    out_off_next    = res_off_reg;
                    out_type_next   = res_type_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            blocks_used_reg <= '0;
            rvalid_reg      <= '0;
            dflt_reg        <= DFLT_BLOCK_SIZE;
            tcount_reg      <= '0;
            tflags_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            blocks_used_reg <= blocks_used_next;
            rvalid_reg      <= rvalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEFAULT_SIZE: dflt_reg   <= cfg_data;
                    CFG_TYPE_COUNT:   tcount_reg <= cfg_data[2:0];
                    CFG_TYPE_FLAGS:   tflags_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // transaction payload registers
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        sz_reg          <= sz_next;
        a_reg           <= a_next;
        amask_reg       <= amask_next;
        mask_reg        <= mask_next;
        rflags_reg      <= rflags_next;
        begin_reg       <= begin_next;
        bnum_reg        <= bnum_next;
        t_reg           <= t_next;
        have_slot_reg   <= have_slot_next;
        bcnt_reg        <= bcnt_next;
        blk_reg         <= blk_next;
        rcnt_reg        <= rcnt_next;
        st_reg          <= st_next;
        ln_reg          <= ln_next;
        pad_reg         <= pad_next;
        best_found_reg  <= best_found_next;
        best_idx_reg    <= best_idx_next;
        best_st_reg     <= best_st_next;
        best_ln_reg     <= best_ln_next;
        best_pad_reg    <= best_pad_next;
        best_need_reg   <= best_need_next;
        al_reg          <= al_next;
        hend_reg        <= hend_next;
        tail_reg        <= tail_next;
        cur_reg         <= cur_next;
        blen_reg        <= blen_next;
        c_reg           <= c_next;
        nsum_reg        <= nsum_next;
        end_reg         <= end_next;
        flen_reg        <= flen_next;
        prev_found_reg  <= prev_found_next;
        prev_idx_reg    <= prev_idx_next;
        prev_st_reg     <= prev_st_next;
        prev_ln_reg     <= prev_ln_next;
        next_found_reg  <= next_found_next;
        next_idx_reg    <= next_idx_next;
        next_st_reg     <= next_st_next;
        next_ln_reg     <= next_ln_next;
        mp_reg          <= mp_next;
        mn_reg          <= mn_next;
        sum1_reg        <= sum1_next;
        res_status_reg  <= res_status_next;
        res_blk_reg     <= res_blk_next;
        res_off_reg     <= res_off_next;
        res_type_reg    <= res_type_next;
        out_status_reg  <= out_status_next;
        out_blk_reg     <= out_blk_next;
        out_off_reg     <= out_off_next;
        out_type_reg    <= out_type_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ffra_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level assertions for the range allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffra_checker import ffra_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [2:0]  rsp_granted_block,
    input wire logic [31:0] rsp_granted_offset,
    input wire logic [1:0]  rsp_granted_type
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transaction taken while busy");

    a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |->
            rsp_granted_block == '0 && rsp_granted_offset == '0 && rsp_granted_type == '0)
        else $error("grant fields set on error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= ST_UNKNOWN_BLOCK)
        else $error("undefined status code");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_granted_block  (rsp.granted_block),
    .rsp_granted_offset (rsp.granted_offset),
    .rsp_granted_type   (rsp.granted_type)
);
`default_nettype wire

// ===== tb/sv/first_fit_range_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_tb
// Drives allocate and free transactions into the range allocator and checks
// every response against an in-bench model of the block and range tables.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_tb;
    import ffra_pkg::*;

    localparam int NBLK = 8;
    localparam int NRNG = 32;
    localparam longint unsigned WORD_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic        mode;
        word_t       size;
        logic [30:0] alignment;
        logic [3:0]  type_mask;
        logic [7:0]  required_flags;
        logic [2:0]  block_number;
        word_t       start_offset;
    } op_t;

    typedef struct {
        logic [2:0] status;
        logic [2:0] granted_block;
        word_t      granted_offset;
        logic [1:0] granted_type;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    ffra_req_if req ();
    ffra_rsp_if rsp ();

    first_fit_range_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator model: block table, free-range table, config shadow
    // ------------------------------------------------------------------
    word_t       dflt_size = DFLT_BLOCK_SIZE;
    logic [2:0]  type_cnt  = '0;
    word_t       type_flg  = '0;

    bit          blk_on [NBLK];
    word_t       blk_len [NBLK];
    word_t       blk_cur [NBLK];
    logic [1:0]  blk_kind [NBLK];
    int          blk_count;
    bit          rng_on [NRNG];
    logic [2:0]  rng_blk [NRNG];
    word_t       rng_lo [NRNG];
    word_t       rng_len [NRNG];

    // allocations still held, used to build well-formed frees
    logic [2:0]  held_blk [$];
    word_t       held_off [$];
    word_t       held_len [$];

    op_t         pending_ops [$];
    grant_t      expected_grants [$];

    int          send_idle = 0;   // percent of cycles the sender sits idle
    int          rsp_stall = 0;   // percent of cycles the response is stalled
    int          fail_count = 0;
    int          mismatch_count = 0;

    function automatic int free_slot();
        for (int r = 0; r < NRNG; r++)
            if (!rng_on[r])
                return r;
        return -1;
    endfunction

    function automatic longint unsigned round_up(longint unsigned x, longint unsigned a);
        return (x + a - 1) & ~(a - 1);
    endfunction

    function automatic grant_t alloc_predict(op_t op);
        grant_t g;
        longint unsigned sz, a, c, st, ln, al, pad, tail, best_al, nlen;
        int n, t, best, s;
        bit found, have_slot;
        g = '{default: '0};
        sz = op.size;
        a = op.alignment;
        a = (a != 0) ? (a & (~a + 1)) : 1;   // lowest set bit; zero acts as 1
        n = (type_cnt > 4) ? 4 : type_cnt;
        found = 1'b0;
        t = 0;
        for (int i = 0; i < n && !found; i++)
            if (op.type_mask[i] && ((type_flg[8*i +: 8] & op.required_flags)
                                    == op.required_flags))
            begin
                t = i;
                found = 1'b1;
            end
        if (!found)
        begin
            g.status = ST_NO_TYPE;
            return g;
        end
        have_slot = free_slot() >= 0;
        for (int b = 0; b < NBLK; b++)
        begin
            if (!blk_on[b] || blk_kind[b] != t[1:0])
                continue;
            best = -1;
            best_al = 0;
            for (int r = 0; r < NRNG; r++)
            begin
                if (!rng_on[r] || rng_blk[r] != b[2:0])
                    continue;
                st = rng_lo[r];
                ln = rng_len[r];
                al = round_up(st, a);
                pad = al - st;
                if (ln < pad + sz)
                    continue;
                // split needing a second slot is skipped when the table is full
                if (pad > 0 && ln - pad - sz > 0 && !have_slot)
                    continue;
                if (best < 0 || rng_lo[r] < rng_lo[best])
                begin
                    best = r;
                    best_al = al;
                end
            end
            if (best >= 0)
            begin
                st = rng_lo[best];
                ln = rng_len[best];
                pad = best_al - st;
                tail = ln - pad - sz;
                if (pad > 0)
                begin
                    rng_len[best] = pad[31:0];
                    if (tail > 0)
                    begin
                        s = free_slot();
                        rng_on[s] = 1'b1;
                        rng_blk[s] = b[2:0];
                        rng_lo[s] = word_t'(best_al + sz);
                        rng_len[s] = tail[31:0];
                    end
                end
                else if (tail > 0)
                begin
                    rng_lo[best] = word_t'(best_al + sz);
                    rng_len[best] = tail[31:0];
                end
                else
                    rng_on[best] = 1'b0;
                g.granted_block = b[2:0];
                g.granted_offset = best_al[31:0];
                g.granted_type = t[1:0];
                return g;
            end
            c = round_up(blk_cur[b], a);
            if (c + sz <= blk_len[b])
            begin
                blk_cur[b] = word_t'(c + sz);
                g.granted_block = b[2:0];
                g.granted_offset = c[31:0];
                g.granted_type = t[1:0];
                return g;
            end
        end
        if (blk_count >= NBLK)
        begin
            g.status = ST_BLOCKS_FULL;
            return g;
        end
        nlen = sz + a;
        if (nlen < dflt_size)
            nlen = dflt_size;
        if (nlen > WORD_MAX)
            nlen = WORD_MAX;
        blk_on[blk_count] = 1'b1;
        blk_len[blk_count] = nlen[31:0];
        blk_cur[blk_count] = sz[31:0];
        blk_kind[blk_count] = t[1:0];
        g.granted_block = blk_count[2:0];
        g.granted_type = t[1:0];
        blk_count++;
        return g;
    endfunction

    function automatic grant_t free_predict(op_t op);
        grant_t g;
        longint unsigned lo, hi, len;
        int b, prv, nxt, s;
        bit mp, mn;
        g = '{default: '0};
        b = op.block_number;
        if (!blk_on[b])
        begin
            g.status = ST_UNKNOWN_BLOCK;
            return g;
        end
        lo = op.start_offset;
        hi = lo + op.size;
        if (hi > WORD_MAX)
            hi = WORD_MAX;
        len = hi - lo;
        if (len == 0)
            return g;
        prv = -1;
        nxt = -1;
        for (int r = 0; r < NRNG; r++)
        begin
            if (!rng_on[r] || rng_blk[r] != b[2:0])
                continue;
            if (rng_lo[r] < lo)
            begin
                if (prv < 0 || rng_lo[r] > rng_lo[prv])
                    prv = r;
            end
            else if (nxt < 0 || rng_lo[r] < rng_lo[nxt])
                nxt = r;
        end
        if (nxt >= 0 && rng_lo[nxt] == lo)
            return g;
        mp = prv >= 0 && (64'(rng_lo[prv]) + rng_len[prv] == lo);
        mn = nxt >= 0 && (hi == rng_lo[nxt]);
        if (mp && mn)
        begin
            rng_len[prv] = word_t'(64'(rng_len[prv]) + len + rng_len[nxt]);
            rng_on[nxt] = 1'b0;
        end
        else if (mp)
            rng_len[prv] = word_t'(64'(rng_len[prv]) + len);
        else if (mn)
        begin
            rng_lo[nxt] = lo[31:0];
            rng_len[nxt] = word_t'(len + rng_len[nxt]);
        end
        else
        begin
            s = free_slot();
            if (s < 0)
            begin
                g.status = ST_RANGES_FULL;
                return g;
            end
            rng_on[s] = 1'b1;
            rng_blk[s] = b[2:0];
            rng_lo[s] = lo[31:0];
            rng_len[s] = len[31:0];
        end
        return g;
    endfunction

    // queue a transaction and its predicted grant
    task automatic send_op(op_t op);
        grant_t g;
        if (op.mode == MODE_FREE)
            g = free_predict(op);
        else
        begin
            g = alloc_predict(op);
            if (g.status == ST_OK)
            begin
                held_blk = {held_blk, g.granted_block};
                held_off = {held_off, g.granted_offset};
                held_len = {held_len, op.size};
            end
        end
        pending_ops = {pending_ops, op};
        expected_grants = {expected_grants, g};
    endtask

    task automatic send_alloc(word_t sz, logic [30:0] al, logic [3:0] msk, logic [7:0] flg);
        op_t op;
        op = '{mode: MODE_ALLOC, size: sz, alignment: al, type_mask: msk,
               required_flags: flg, block_number: 3'($urandom), start_offset: $urandom};
        send_op(op);
    endtask

    task automatic send_free(logic [2:0] blk, word_t off, word_t sz);
        op_t op;
        op = '{mode: MODE_FREE, size: sz, alignment: 31'($urandom),
               type_mask: 4'($urandom), required_flags: 8'($urandom),
               block_number: blk, start_offset: off};
        send_op(op);
    endtask

    // sender pauses until every outstanding grant has come back
    task automatic drain();
        wait (pending_ops.size() == 0 && expected_grants.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // register writes only happen with the block idle
    task automatic write_reg(logic [1:0] idx, word_t v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEFAULT_SIZE)
            dflt_size = v;
        else if (idx == CFG_TYPE_COUNT)
            type_cnt = v[2:0];
        else if (idx == CFG_TYPE_FLAGS)
            type_flg = v;
    endtask

    task automatic random_op();
        int k, pick;
        word_t off, sz;
        k = $urandom_range(99);
        if (k < 45 || (k < 92 && held_blk.size() == 0))
            send_alloc(($urandom_range(9) == 0) ? $urandom_range(1, 4096)
                                                : $urandom_range(1, 64),
                       31'(1) << $urandom_range(0, 6),
                       ($urandom_range(3) == 0) ? 4'hF : 4'($urandom_range(1, 15)),
                       ($urandom_range(2) == 0) ? 8'($urandom) : 8'h00);
        else if (k < 85)
        begin
            // well-formed free of a held allocation
            pick = $urandom_range(held_blk.size() - 1);
            send_free(held_blk[pick], held_off[pick], held_len[pick]);
            held_blk.delete(pick);
            held_off.delete(pick);
            held_len.delete(pick);
        end
        else if (k < 92)
        begin
            // partial slice or double free of a held allocation
            pick = $urandom_range(held_blk.size() - 1);
            off = held_off[pick] + $urandom_range(0, 3);
            sz = $urandom_range(0, held_len[pick]);
            send_free(held_blk[pick], off, sz);
        end
        else
        begin
            // noise: every field random
            if ($urandom_range(1))
                send_free(3'($urandom), $urandom, $urandom);
            else
                send_alloc($urandom, 31'($urandom), 4'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: next transaction goes out once the bus is free
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        op_t op;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= MODE_ALLOC;
            req.size <= '0;
            req.alignment <= '0;
            req.type_mask <= '0;
            req.required_flags <= '0;
            req.block_number <= '0;
            req.start_offset <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                op = pending_ops.pop_front();
                req.valid <= 1'b1;
                req.mode <= op.mode;
                req.size <= op.size;
                req.alignment <= op.alignment;
                req.type_mask <= op.type_mask;
                req.required_flags <= op.required_flags;
                req.block_number <= op.block_number;
                req.start_offset <= op.start_offset;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: every accepted transaction is checked in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            rsp.ready <= ($urandom_range(99) >= rsp_stall);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response: status %0d", rsp.status);
                end
                else
                begin
                    g = expected_grants.pop_front();
                    if (rsp.status !== g.status || rsp.granted_block !== g.granted_block ||
                        rsp.granted_offset !== g.granted_offset ||
                        rsp.granted_type !== g.granted_type)
                    begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp st %0d blk %0d off %h typ %0d, ",
                                      "got st %0d blk %0d off %h typ %0d"},
                                     g.status, g.granted_block, g.granted_offset,
                                     g.granted_type, rsp.status, rsp.granted_block,
                                     rsp.granted_offset, rsp.granted_type);
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int idle_tab [4][2];
        word_t dflt_tab [4];
        cfg_we = 1'b0;
        cfg_index = CFG_DEFAULT_SIZE;
        cfg_data = '0;
        idle_tab = '{'{0, 0}, '{83, 0}, '{0, 83}, '{16, 16}};
        dflt_tab = '{32'd4096, 32'h8000_0000, 32'd1, 32'd256};
        blk_count = 0;
        foreach (blk_on[i]) blk_on[i] = 1'b0;
        foreach (rng_on[i]) rng_on[i] = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: no types present, no blocks yet
        send_alloc(32'd16, 31'd1, 4'hF, 8'h00);
        send_free(3'd0, 32'd0, 32'd16);
        drain();

        // tiny blocks; type count above four; t0=80 t1=01 t2=03 t3=FF
        write_reg(CFG_DEFAULT_SIZE, 32'd1);
        write_reg(CFG_TYPE_COUNT, 32'd7);
        write_reg(CFG_TYPE_FLAGS, 32'hFF03_0180);
        send_alloc(32'd100, 31'd0, 4'hF, 8'h00);              // zero alignment
        send_alloc(32'd1, 31'd6, 4'hF, 8'h01);                // non power of two
        send_alloc(32'd8, 31'd1, 4'h0, 8'h00);                // empty mask
        send_alloc(32'd8, 31'd1, 4'h7, 8'h10);                // flags unmatched
        send_alloc(32'hFFFF_FFFF, 31'h4000_0000, 4'h8, 8'hFF); // length saturates
        send_alloc(32'h8000_0000, 31'h7FFF_FFFF, 4'h4, 8'h02);
        send_free(3'd0, 32'd10, 32'd20);
        send_free(3'd0, 32'd10, 32'd5);                       // at start of free range
        send_free(3'd0, 32'd30, 32'd0);                       // zero length
        send_free(3'd0, 32'd0, 32'd10);                       // merges above
        send_free(3'd0, 32'd50, 32'd10);
        send_free(3'd0, 32'd30, 32'd20);                      // merges both sides
        send_free(3'd2, 32'hFFFF_FFF0, 32'h100);              // clipped at top
        send_free(3'd7, 32'd0, 32'd4);                        // unknown block
        send_alloc(32'd8, 31'd16, 4'h1, 8'h00);               // aligned out of a range
        send_alloc(32'd3, 31'd4, 4'h2, 8'h01);                // no room at block 1 cursor; new block
        drain();

        // random traffic, one idle pattern and one config per phase
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_DEFAULT_SIZE, dflt_tab[p]);
            write_reg(CFG_TYPE_COUNT, (p == 2) ? 32'd3 : 32'd4);
            write_reg(CFG_TYPE_FLAGS, (p == 2) ? $urandom
                                    : (p == 3) ? 32'hFFFF_FFFF : 32'hFF03_0180);
            send_idle = idle_tab[p][0];
            rsp_stall = idle_tab[p][1];
            for (int i = 0; i < 320; i++)
            begin
                random_op();
                if (i == 160)
                    drain();   // sender waits out every open grant
            end
            drain();
        end
        send_idle = 0;
        rsp_stall = 0;

        // fill the range table, then force the split-without-slot skip
        write_reg(CFG_TYPE_COUNT, 32'd4);
        write_reg(CFG_TYPE_FLAGS, 32'hFF03_0180);
        for (int i = 0; i < 34; i++)
            send_free(3'd2, 32'h1000_0001 + 32'(i) * 32'd16, 32'd8);
        for (int i = 0; i < 3; i++)
            send_alloc(32'd2, 31'd4, 4'h8, 8'hFF);
        for (int i = 0; i < 4; i++)
            send_alloc(32'd8, 31'd1, 4'h8, 8'hFF);

        wait (pending_ops.size() == 0 && expected_grants.size() == 0);
        repeat (200) @(posedge clk);
        if (expected_grants.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_if.sv
hw/rtl/ffra_ram.sv
hw/rtl/first_fit_range_allocator.sv
hw/rtl/ffra_checker.sv
tb/sv/first_fit_range_allocator_tb.sv
